FILE: rtl/core/quaternion_arith_unit_assert.svh
// Assertion macros shared by the quaternion arithmetic unit.
`ifndef QUATERNION_ARITH_UNIT_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define QAU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define QAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/qau_pkg.sv
// Package: types, codes and constants of the quaternion arithmetic unit.
`default_nettype none
package qau_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits  = 12;
   localparam int SumWidth  = 2 * DataWidth + 2;
   localparam int QuotBits  = DataWidth + 2 * FracBits;
   localparam int RootBits  = SumWidth / 2;
   localparam int DivSteps  = QuotBits;
   localparam int RootSteps = RootBits;
   localparam int PipeDepth = 2 + DivSteps;
   localparam int QueueDepth = 4;

   typedef logic signed [DataWidth-1:0] word_type;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_CONJ = 3'd3,
      OP_NORM = 3'd4,
      OP_INV  = 3'd5,
      OP_NOP6 = 3'd6,
      OP_NOP7 = 3'd7
   } op_type;

   typedef struct packed {
      op_type   op;
      word_type a_w, a_x, a_y, a_z;
      word_type b_w, b_x, b_y, b_z;
   } item_type;

   typedef struct packed {
      word_type r_w, r_x, r_y, r_z;
      logic     saturated;
      logic     zero_divide;
   } result_type;

   localparam int ItemWidth   = $bits(item_type);
   localparam int ResultWidth = $bits(result_type);

   localparam logic signed [DataWidth+1:0] WordMax = (DataWidth+2)'((1 << (DataWidth-1)) - 1);
   localparam logic signed [DataWidth+1:0] WordMin = -WordMax - (DataWidth+2)'(1);

   function automatic word_type clip18(input logic signed [DataWidth+1:0] v,
                                       output logic sat);
      word_type r;
      sat = 1'b0;
      r = v[DataWidth-1:0];
      if (v > WordMax) begin
         r = WordMax[DataWidth-1:0];
         sat = 1'b1;
      end else if (v < WordMin) begin
         r = WordMin[DataWidth-1:0];
         sat = 1'b1;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/quaternion_arith_unit.sv
// Top level of the quaternion arithmetic unit: front queue and back datapath.
//  channel | dir | tdata fields (low bit first)                 | tuser fields
//  req     | in  | left w,x,y,z, right w,x,y,z (16 b each)      | req_type[2:0]
//  rsp     | out | out_w, out_x, out_y, out_z (16 b each)       | saturated, zero_divide
// One item a cycle sustained while rsp_tready stays high; the path from request
// transfer to response transfer runs through the 40-stage divide pipeline plus
// the two queues and the product, sum and setup stages.
// Synchronous reset empties both queues and the pipeline.
// rsp_tready low stalls results in the output queue; the input stops once the
// credit count of items in flight, queued and presented reaches PipeDepth + 4.
`default_nettype none
module quaternion_arith_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
   input  wire logic [127:0] req_tdata,
   // req_type
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_w, out_x, out_y, out_z
   output logic [63:0]       rsp_tdata,
   // saturated, zero_divide
   output logic [1:0]        rsp_tuser
);
   import qau_pkg::*;

   item_type   req_item;
   item_type   q_item;
   result_type res;
   logic       q_valid, q_ready;

   always_comb begin
      req_item.op  = op_type'(req_tuser);
      req_item.a_w = req_tdata[15:0];
      req_item.a_x = req_tdata[31:16];
      req_item.a_y = req_tdata[47:32];
      req_item.a_z = req_tdata[63:48];
      req_item.b_w = req_tdata[79:64];
      req_item.b_x = req_tdata[95:80];
      req_item.b_y = req_tdata[111:96];
      req_item.b_z = req_tdata[127:112];
   end

   qau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   qau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_result(res)
   );

   assign rsp_tdata = {res.r_z, res.r_y, res.r_x, res.r_w};
   assign rsp_tuser = {res.zero_divide, res.saturated};
endmodule
`default_nettype wire

FILE: rtl/core/qau_ram.sv
// Generic memory with one write port and a registered read port.
`default_nettype none
module qau_ram #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/qau_front.sv
// Front end: accept requests, classify them and write them into the item queue.
`default_nettype none
module qau_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire qau_pkg::item_type   req_item,
   output logic                     q_valid,
   input  wire logic                q_ready,
   output qau_pkg::item_type        q_item
);
   import qau_pkg::*;
   `include "quaternion_arith_unit_assert.svh"

   localparam int AddrBits = $clog2(QueueDepth);

   logic [AddrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AddrBits:0]   count_ff, count_in;
   logic                out_valid_ff, out_valid_in;
   logic                push, pop, load;
   item_type            clean;
   item_type            rd_data;
   item_type            hold_ff, hold_in;
   logic                fresh_ff, fresh_in;

   // Unused codes become a harmless no-op with zero operands.
   always_comb begin
      clean = req_item;
      case (req_item.op)
         OP_NOP6, OP_NOP7: begin
            clean = '0;
            clean.op = OP_NOP6;
         end
         default: clean = req_item;
      endcase
   end

   assign req_tready = (count_ff < (AddrBits+1)'(QueueDepth));
   assign push = req_tvalid && req_tready;
   // Memory word goes out when the output stage is empty or draining.
   assign load = (count_ff != '0) && (!out_valid_ff || q_ready);
   assign pop  = load;

   qau_ram #(.Width(ItemWidth), .Depth(QueueDepth)) u_queue (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(wr_ptr_ff),
      .wr_data(clean),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      wr_ptr_in    = push ? wr_ptr_ff + AddrBits'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + AddrBits'(1) : rd_ptr_ff;
      count_in     = count_ff + (AddrBits+1)'(push) - (AddrBits+1)'(pop);
      out_valid_in = load ? 1'b1 : (q_ready ? 1'b0 : out_valid_ff);
      fresh_in     = load;
      hold_in      = fresh_ff ? rd_data : hold_ff;
   end

   // Read data lands in the cycle after the pop; a write to the same slot
   // in the pop cycle cannot happen since the slot was already occupied.
   assign q_item  = fresh_ff ? rd_data : hold_ff;
   assign q_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         fresh_ff     <= fresh_in;
      end
      hold_ff <= hold_in;
   end

   `QAU_ASSERT_IMPLY(a_no_overfill, clock, reset, 1'b1,
      count_ff <= (AddrBits+1)'(QueueDepth), "item queue overfilled")
   `QAU_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, count_ff != '0,
      "pop from empty item queue")
   `QAU_ASSERT_NEXT(a_load_valid, clock, reset, load, q_valid,
      "loaded item not presented")
endmodule
`default_nettype wire

FILE: rtl/core/qau_back.sv
// Back end: pipelined add, product, root and divide datapath with output skid.
`default_nettype none
module qau_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire qau_pkg::item_type   q_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output qau_pkg::result_type      rsp_result
);
   import qau_pkg::*;
   `include "quaternion_arith_unit_assert.svh"

   localparam int ProdWidth = 2 * DataWidth;
   localparam int AccWidth  = ProdWidth + 3;
   localparam int CntBits   = $clog2(PipeDepth + 5);

   typedef logic signed [ProdWidth-1:0] prod_type;
   typedef logic [SumWidth-1:0]         sum_type;

   // Stage registers, indexed 0..PipeDepth-1; stage k is fed by stage k-1, stage 0 by stage M.
   logic                 v_ff   [PipeDepth];
   op_type               op_ff  [PipeDepth];
   result_type           res_ff [PipeDepth];
   word_type             a_ff   [PipeDepth][4];
   logic                 neg_ff [PipeDepth][4];
   sum_type              s_ff   [PipeDepth];
   // Division state for the four lanes.
   logic [SumWidth:0]    rem_ff [PipeDepth][4];
   logic [QuotBits-1:0]  quo_ff [PipeDepth][4];
   // Square root state.
   sum_type              rn_ff  [PipeDepth];
   logic [RootBits:0]    rr_ff  [PipeDepth];

   prod_type p0_ff [16];
   logic     mul_v_ff;
   op_type   mul_op_ff;
   result_type mul_res_ff;
   word_type  mul_a_ff [4];
   logic [ProdWidth-1:0] sq_ff [4];

   logic [CntBits-1:0] credit_ff, credit_in;
   logic               advance;
   logic               q_take;
   logic               rsp_take;

   // Slots reserved in the skid queue cover every item in flight.
   localparam int SkidDepth = 1 << $clog2(PipeDepth + 4);
   localparam int SkBits = $clog2(SkidDepth);

   assign q_ready = (credit_ff < CntBits'(PipeDepth + 4));
   assign q_take  = q_valid && q_ready;
   assign advance = 1'b1;

   // Stage M: operand products, squares and simple operations.
   always_ff @(posedge clock) begin
      word_type a [4];
      word_type b [4];
      logic s0, s1, s2, s3;
      result_type rm;
      a[0] = q_item.a_w; a[1] = q_item.a_x; a[2] = q_item.a_y; a[3] = q_item.a_z;
      b[0] = q_item.b_w; b[1] = q_item.b_x; b[2] = q_item.b_y; b[3] = q_item.b_z;
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else begin
         mul_v_ff <= q_take;
      end
      mul_op_ff <= q_item.op;
      for (int i = 0; i < 4; i++) begin
         mul_a_ff[i] <= a[i];
         sq_ff[i]    <= ProdWidth'(a[i] * a[i]);
         for (int j = 0; j < 4; j++) begin
            p0_ff[i*4+j] <= a[i] * b[j];
         end
      end
      rm = '0;
      s0 = 1'b0;
      s1 = 1'b0;
      s2 = 1'b0;
      s3 = 1'b0;
      case (q_item.op)
         OP_ADD: begin
            rm.r_w = clip18((DataWidth+2)'(a[0]) + (DataWidth+2)'(b[0]), s0);
            rm.r_x = clip18((DataWidth+2)'(a[1]) + (DataWidth+2)'(b[1]), s1);
            rm.r_y = clip18((DataWidth+2)'(a[2]) + (DataWidth+2)'(b[2]), s2);
            rm.r_z = clip18((DataWidth+2)'(a[3]) + (DataWidth+2)'(b[3]), s3);
            rm.saturated = s0 | s1 | s2 | s3;
         end
         OP_SUB: begin
            rm.r_w = clip18((DataWidth+2)'(a[0]) - (DataWidth+2)'(b[0]), s0);
            rm.r_x = clip18((DataWidth+2)'(a[1]) - (DataWidth+2)'(b[1]), s1);
            rm.r_y = clip18((DataWidth+2)'(a[2]) - (DataWidth+2)'(b[2]), s2);
            rm.r_z = clip18((DataWidth+2)'(a[3]) - (DataWidth+2)'(b[3]), s3);
            rm.saturated = s0 | s1 | s2 | s3;
         end
         OP_CONJ: begin
            rm.r_w = a[0];
            rm.r_x = clip18(-(DataWidth+2)'(a[1]), s1);
            rm.r_y = clip18(-(DataWidth+2)'(a[2]), s2);
            rm.r_z = clip18(-(DataWidth+2)'(a[3]), s3);
            rm.saturated = s1 | s2 | s3;
         end
         default: rm = '0;
      endcase
      mul_res_ff <= rm;
   end

   // Stage 0: sums of products, sum of squares, sign of conjugate.
   function automatic word_type round_sum(input prod_type p0, p1, p2, p3,
                                          output logic sat);
      logic signed [AccWidth-1:0] acc;
      logic signed [AccWidth-FracBits-1:0] sh;
      acc = AccWidth'(p0) + AccWidth'(p1) + AccWidth'(p2) + AccWidth'(p3)
          + AccWidth'(1 << (FracBits - 1));
      sh = acc[AccWidth-1:FracBits];
      sat = 1'b0;
      if (sh > (AccWidth-FracBits)'(WordMax)) begin
         sat = 1'b1;
         return WordMax[DataWidth-1:0];
      end
      if (sh < (AccWidth-FracBits)'(WordMin)) begin
         sat = 1'b1;
         return WordMin[DataWidth-1:0];
      end
      return sh[DataWidth-1:0];
   endfunction

   always_ff @(posedge clock) begin
      logic s0, s1, s2, s3;
      result_type r;
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= mul_v_ff;
      end
      op_ff[0] <= mul_op_ff;
      s_ff[0]  <= SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1])
                + SumWidth'(sq_ff[2]) + SumWidth'(sq_ff[3]);
      for (int k = 0; k < 4; k++) begin
         a_ff[0][k]   <= mul_a_ff[k];
         neg_ff[0][k] <= (k == 0) ? mul_a_ff[k][DataWidth-1]
                                  : (mul_a_ff[k] > 0);
      end
      r = mul_res_ff;
      if (mul_op_ff == OP_MUL) begin
         r.r_w = round_sum(p0_ff[0], -p0_ff[5], -p0_ff[10], -p0_ff[15], s0);
         r.r_x = round_sum(p0_ff[1], p0_ff[4], p0_ff[11], -p0_ff[14], s1);
         r.r_y = round_sum(p0_ff[2], -p0_ff[7], p0_ff[8], p0_ff[13], s2);
         r.r_z = round_sum(p0_ff[3], p0_ff[6], -p0_ff[9], p0_ff[12], s3);
         r.saturated = s0 | s1 | s2 | s3;
         r.zero_divide = 1'b0;
      end
      res_ff[0] <= r;
   end

   // Stage 1: set up root and division.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[1] <= 1'b0;
      end else begin
         v_ff[1] <= v_ff[0];
      end
      op_ff[1]  <= op_ff[0];
      res_ff[1] <= res_ff[0];
      s_ff[1]   <= s_ff[0];
      rn_ff[1]  <= s_ff[0];
      rr_ff[1]  <= '0;
      for (int k = 0; k < 4; k++) begin
         a_ff[1][k]   <= a_ff[0][k];
         neg_ff[1][k] <= neg_ff[0][k];
         rem_ff[1][k] <= '0;
         quo_ff[1][k] <= '0;
      end
   end

   // Division and root steps, one quotient bit a stage and one root bit a stage in the last RootBits stages.
   for (genvar g = 2; g < PipeDepth; g++) begin : g_step
      localparam int Bit  = PipeDepth - 1 - g;
      localparam int MBit = (Bit >= 2 * FracBits) ? Bit - 2 * FracBits : 0;
      always_ff @(posedge clock) begin
         logic [SumWidth:0] r2;
         logic [DataWidth-1:0] m;
         logic [RootBits:0] trial;
         logic [SumWidth-1:0] sq;
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else begin
            v_ff[g] <= v_ff[g-1];
         end
         op_ff[g]  <= op_ff[g-1];
         res_ff[g] <= res_ff[g-1];
         s_ff[g]   <= s_ff[g-1];
         for (int k = 0; k < 4; k++) begin
            a_ff[g][k]   <= a_ff[g-1][k];
            neg_ff[g][k] <= neg_ff[g-1][k];
            m = a_ff[g-1][k][DataWidth-1] ? DataWidth'(-a_ff[g-1][k]) : a_ff[g-1][k];
            r2 = {rem_ff[g-1][k][SumWidth-1:0],
                  (Bit >= 2*FracBits) ? m[MBit] : 1'b0};
            if (r2 >= (SumWidth+1)'(s_ff[g-1])) begin
               rem_ff[g][k] <= r2 - (SumWidth+1)'(s_ff[g-1]);
               quo_ff[g][k] <= {quo_ff[g-1][k][QuotBits-2:0], 1'b1};
            end else begin
               rem_ff[g][k] <= r2;
               quo_ff[g][k] <= {quo_ff[g-1][k][QuotBits-2:0], 1'b0};
            end
         end
         // Root: try setting bit Bit when it is inside the root width.
         if (Bit < RootBits) begin
            trial = rr_ff[g-1] | ((RootBits+1)'(1) << Bit);
            sq = SumWidth'(trial) * SumWidth'(trial);
            rr_ff[g] <= (sq <= rn_ff[g-1]) ? trial : rr_ff[g-1];
         end else begin
            rr_ff[g] <= rr_ff[g-1];
         end
         rn_ff[g] <= rn_ff[g-1];
      end
   end

   // Final result selection.
   result_type fin;
   always_comb begin
      logic signed [QuotBits+1:0] v;
      logic s;
      fin = res_ff[PipeDepth-1];
      case (op_ff[PipeDepth-1])
         OP_NORM: begin
            fin = '0;
            if (rr_ff[PipeDepth-1] > (RootBits+1)'(WordMax)) begin
               fin.r_w = WordMax[DataWidth-1:0];
               fin.saturated = 1'b1;
            end else begin
               fin.r_w = rr_ff[PipeDepth-1][DataWidth-1:0];
            end
         end
         OP_INV: begin
            fin = '0;
            if (s_ff[PipeDepth-1] == '0) begin
               fin.zero_divide = 1'b1;
            end else begin
               for (int k = 0; k < 4; k++) begin
                  v = (QuotBits+2)'(quo_ff[PipeDepth-1][k]);
                  if (neg_ff[PipeDepth-1][k]) v = -v;
                  s = 1'b0;
                  if (v > (QuotBits+2)'(WordMax)) begin
                     s = 1'b1;
                     v = (QuotBits+2)'(WordMax);
                  end else if (v < (QuotBits+2)'(WordMin)) begin
                     s = 1'b1;
                     v = (QuotBits+2)'(WordMin);
                  end
                  case (k)
                     0: fin.r_w = v[DataWidth-1:0];
                     1: fin.r_x = v[DataWidth-1:0];
                     2: fin.r_y = v[DataWidth-1:0];
                     default: fin.r_z = v[DataWidth-1:0];
                  endcase
                  fin.saturated = fin.saturated | s;
               end
            end
         end
         default: fin = res_ff[PipeDepth-1];
      endcase
   end

   // Skid queue at the output; credit counts items in flight, queued and presented.
   logic [SkBits-1:0] sk_wr_ff, sk_wr_in, sk_rd_ff, sk_rd_in;
   logic [SkBits:0]   sk_cnt_ff, sk_cnt_in;
   logic              sk_push, sk_load;
   logic              out_valid_ff, out_valid_in;
   logic              fresh_ff;
   result_type        sk_rd_data;
   result_type        hold_ff, hold_in;

   assign sk_push = v_ff[PipeDepth-1] && advance;
   assign sk_load = (sk_cnt_ff != '0) && (!out_valid_ff || rsp_ready);

   qau_ram #(.Width(ResultWidth), .Depth(SkidDepth)) u_skid (
      .clock  (clock),
      .wr_en  (sk_push),
      .wr_addr(sk_wr_ff),
      .wr_data(fin),
      .rd_addr(sk_rd_ff),
      .rd_data(sk_rd_data)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_take   = rsp_valid && rsp_ready;
   assign rsp_result = fresh_ff ? sk_rd_data : hold_ff;

   always_comb begin
      sk_wr_in     = sk_push ? sk_wr_ff + SkBits'(1) : sk_wr_ff;
      sk_rd_in     = sk_load ? sk_rd_ff + SkBits'(1) : sk_rd_ff;
      sk_cnt_in    = sk_cnt_ff + (SkBits+1)'(sk_push) - (SkBits+1)'(sk_load);
      out_valid_in = sk_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      hold_in      = fresh_ff ? sk_rd_data : hold_ff;
      credit_in    = credit_ff + CntBits'(q_take) - CntBits'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_wr_ff     <= '0;
         sk_rd_ff     <= '0;
         sk_cnt_ff    <= '0;
         credit_ff    <= '0;
         out_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         sk_wr_ff     <= sk_wr_in;
         sk_rd_ff     <= sk_rd_in;
         sk_cnt_ff    <= sk_cnt_in;
         credit_ff    <= credit_in;
         out_valid_ff <= out_valid_in;
         fresh_ff     <= sk_load;
      end
      hold_ff <= hold_in;
   end

   `QAU_ASSERT_IMPLY(a_skid_room, clock, reset, sk_push,
      sk_cnt_ff < (SkBits+1)'(SkidDepth), "output skid overflow")
   `QAU_ASSERT_IMPLY(a_credit_cover, clock, reset, 1'b1,
      credit_ff >= CntBits'(sk_cnt_ff) + CntBits'(out_valid_ff),
      "credit below queued results")
   `QAU_ASSERT_IMPLY(a_zdiv_inv, clock, reset, sk_push && fin.zero_divide,
      op_ff[PipeDepth-1] == OP_INV, "zero divide on non-inverse")
endmodule
`default_nettype wire
